@@ rtl/core/nprs_pkg.sv @@
// nprs_pkg: shared types and constants of the nearest pending request server
`default_nettype none

package nprs_pkg;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned DIST_W = 48;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_SERVE = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic             is_serve;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic              served;
    logic [POS_W-1:0]  pos;
    logic [DIST_W-1:0] total;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/nprs_front.sv @@
// nprs_front: input queue that takes beats, drops out-of-range adds and buffers commands
`default_nettype none

module nprs_front #(
  parameter int unsigned POSITIONS = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      req_type_i,
  input  wire logic [nprs_pkg::POS_W-1:0] position_i,
  input  wire logic [nprs_pkg::POS_W-1:0] track_length_i,
  output logic                           cmd_valid_o,
  output nprs_pkg::cmd_t                 cmd_o,
  input  wire logic                      cmd_pop_i
);

  nprs_pkg::cmd_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       keep, do_wr, do_rd;

  // adds past the end of the line are taken but never queued
  assign keep = (req_type_i == nprs_pkg::REQ_SERVE) ||
                ((position_i <= track_length_i) && (32'(position_i) < POSITIONS));

  assign full        = (cnt_q == 2'd2);
  assign do_wr       = push && !full && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_rd       = cmd_valid_o && cmd_pop_i;
  assign cmd_o       = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_q <= ~wr_q;
      end
      if (do_rd) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      ent_q[wr_q].is_serve <= req_type_i;
      ent_q[wr_q].pos      <= position_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nprs_back.sv @@
// nprs_back: count store, row occupancy scan, head tracking and result queue
`default_nettype none

module nprs_back #(
  parameter int unsigned POSITIONS  = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [nprs_pkg::POS_W-1:0]  track_length_i,
  input  wire logic                        cmd_valid_i,
  input  nprs_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             served_o,
  output logic [nprs_pkg::POS_W-1:0]       served_position_o,
  output logic [nprs_pkg::DIST_W-1:0]      total_distance_o
);

  localparam int unsigned W    = (POSITIONS < 32) ? (2 ** $clog2(POSITIONS)) : 32;
  localparam int unsigned CB   = $clog2(W);
  localparam int unsigned ROWS = (POSITIONS + W - 1) / W;
  localparam int unsigned RB   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned AW   = RB + CB;
  localparam int unsigned XW   = (AW > nprs_pkg::POS_W) ? AW : nprs_pkg::POS_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [W-1:0] ONES = {W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADD_WR, ST_L_CHK, ST_R_CHK, ST_DECIDE, ST_UPD
  } state_e;

  // memories: occupancy rows mark which counts are live
  logic [W-1:0]          occ_mem [ROWS];
  logic [COUNT_BITS-1:0] cnt_mem [ROWS*W];
  logic [W-1:0]          occ_rdata_q;
  logic [COUNT_BITS-1:0] cnt_rdata_q;

  logic                  occ_re, occ_we, cnt_re, cnt_we;
  logic [RB-1:0]         occ_raddr, occ_waddr;
  logic [W-1:0]          occ_wdata;
  logic [AW-1:0]         cnt_raddr, cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  state_e              state_q, state_d;
  logic [RB-1:0]       clr_q, clr_d, row_q, row_d;
  logic [AW-1:0]       head_q, head_d, left_q, left_d, right_q, right_d;
  logic [AW-1:0]       tgt_q, tgt_d, addr_q, addr_d;
  logic                dir_q, dir_d, hl_q, hl_d, hr_q, hr_d;
  logic [nprs_pkg::DIST_W-1:0] dist_q, dist_d;

  // result queue
  nprs_pkg::res_t res_q [2];
  logic [1:0]     rcnt_q, rcnt_d;
  logic           rwr_q, rrd_q, rpush, rdo_rd;
  nprs_pkg::res_t rres;

  // helpers
  logic [XW-1:0]  cmd_x, lim_x, tl_x, pm_x, head_x;
  logic [AW-1:0]  cmd_pos, lim, start, dl, dr, tgt_c;
  logic [CB-1:0]  hi_col, lo_col;
  logic           hi_any, lo_any;
  logic [W-1:0]   lmask, rmask, limmask, lmasked, rmasked;
  logic           cur_live;
  logic [COUNT_BITS-1:0] cur_cnt, dec_cnt;
  logic [AW-1:0]  mv;
  logic [nprs_pkg::DIST_W:0] dsum;

  function automatic logic [nprs_pkg::POS_W-1:0] tgt_x_pos(input logic [AW-1:0] p);
    logic [XW-1:0] px;
    px = XW'(p);
    return px[nprs_pkg::POS_W-1:0];
  endfunction

  assign cmd_x   = XW'(cmd_i.pos);
  assign cmd_pos = cmd_x[AW-1:0];
  assign tl_x    = XW'(track_length_i);
  assign pm_x    = XW'(POSITIONS - 1);
  assign lim_x   = (tl_x < pm_x) ? tl_x : pm_x;
  assign lim     = lim_x[AW-1:0];
  assign start   = (head_q < lim) ? head_q : lim;
  assign head_x  = XW'(head_q);

  assign lmask   = (row_q == start[AW-1:CB]) ?
                   (ONES >> (CB'(W - 1) - start[CB-1:0])) : ONES;
  assign rmask   = (row_q == head_q[AW-1:CB]) ? (ONES << head_q[CB-1:0]) : ONES;
  assign limmask = (row_q == lim[AW-1:CB]) ?
                   (ONES >> (CB'(W - 1) - lim[CB-1:0])) : ONES;
  assign lmasked = occ_rdata_q & lmask;
  assign rmasked = occ_rdata_q & rmask & limmask;

  always_comb begin
    hi_col = '0;
    hi_any = 1'b0;
    for (int i = 0; i < W; i++) begin
      if (lmasked[i]) begin
        hi_col = CB'(i);
        hi_any = 1'b1;
      end
    end
  end

  always_comb begin
    lo_col = '0;
    lo_any = 1'b0;
    for (int i = W - 1; i >= 0; i--) begin
      if (rmasked[i]) begin
        lo_col = CB'(i);
        lo_any = 1'b1;
      end
    end
  end

  assign cur_live = occ_rdata_q[addr_q[CB-1:0]];
  assign cur_cnt  = cur_live ? cnt_rdata_q : '0;
  assign dec_cnt  = cnt_rdata_q - COUNT_BITS'(1);
  assign dl       = head_q - left_q;
  assign dr       = right_q - head_q;
  assign mv       = (tgt_q >= head_q) ? (tgt_q - head_q) : (head_q - tgt_q);
  assign dsum     = {1'b0, dist_q} + (nprs_pkg::DIST_W + 1)'(mv);

  always_comb begin
    if (!hr_q) begin
      tgt_c = left_q;
    end else if (!hl_q) begin
      tgt_c = right_q;
    end else if (dl == dr) begin
      tgt_c = dir_q ? right_q : left_q;
    end else if (dl < dr) begin
      tgt_c = left_q;
    end else begin
      tgt_c = right_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    row_d     = row_q;
    head_d    = head_q;
    left_d    = left_q;
    right_d   = right_q;
    tgt_d     = tgt_q;
    addr_d    = addr_q;
    dir_d     = dir_q;
    hl_d      = hl_q;
    hr_d      = hr_q;
    dist_d    = dist_q;
    occ_re    = 1'b0;
    occ_raddr = row_q;
    occ_we    = 1'b0;
    occ_waddr = row_q;
    occ_wdata = occ_rdata_q;
    cnt_re    = 1'b0;
    cnt_raddr = addr_q;
    cnt_we    = 1'b0;
    cnt_waddr = addr_q;
    cnt_wdata = cnt_rdata_q;
    cmd_pop_o = 1'b0;
    rpush     = 1'b0;
    rres.served = 1'b0;
    rres.pos    = head_x[nprs_pkg::POS_W-1:0];
    rres.total  = dist_q;

    case (state_q)
      ST_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = '0;
        clr_d     = clr_q + RB'(1);
        if (clr_q == RB'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.is_serve == nprs_pkg::REQ_ADD) begin
            cmd_pop_o = 1'b1;
            addr_d    = cmd_pos;
            occ_re    = 1'b1;
            occ_raddr = cmd_pos[AW-1:CB];
            cnt_re    = 1'b1;
            cnt_raddr = cmd_pos;
            state_d   = ST_ADD_WR;
          end else if (rcnt_q != 2'd2) begin
            cmd_pop_o = 1'b1;
            row_d     = start[AW-1:CB];
            occ_re    = 1'b1;
            occ_raddr = start[AW-1:CB];
            state_d   = ST_L_CHK;
          end
        end
      end
      ST_ADD_WR: begin
        if (cur_cnt != CNT_MAX) begin
          cnt_we    = 1'b1;
          cnt_wdata = cur_cnt + COUNT_BITS'(1);
          occ_we    = 1'b1;
          occ_waddr = addr_q[AW-1:CB];
          occ_wdata = occ_rdata_q | (W'(1) << addr_q[CB-1:0]);
        end
        state_d = ST_IDLE;
      end
      ST_L_CHK: begin
        if (hi_any || row_q == '0) begin
          hl_d   = hi_any;
          left_d = {row_q, hi_col};
          if (head_q > lim) begin
            hr_d    = 1'b0;
            state_d = ST_DECIDE;
          end else begin
            row_d     = head_q[AW-1:CB];
            occ_re    = 1'b1;
            occ_raddr = head_q[AW-1:CB];
            state_d   = ST_R_CHK;
          end
        end else begin
          row_d     = row_q - RB'(1);
          occ_re    = 1'b1;
          occ_raddr = row_q - RB'(1);
        end
      end
      ST_R_CHK: begin
        if (lo_any || row_q == lim[AW-1:CB]) begin
          hr_d    = lo_any;
          right_d = {row_q, lo_col};
          state_d = ST_DECIDE;
        end else begin
          row_d     = row_q + RB'(1);
          occ_re    = 1'b1;
          occ_raddr = row_q + RB'(1);
        end
      end
      ST_DECIDE: begin
        if (!hl_q && !hr_q) begin
          rpush   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          tgt_d     = tgt_c;
          addr_d    = tgt_c;
          occ_re    = 1'b1;
          occ_raddr = tgt_c[AW-1:CB];
          cnt_re    = 1'b1;
          cnt_raddr = tgt_c;
          if (tgt_c != head_q) begin
            dir_d = (tgt_c > head_q);
          end
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cnt_we    = 1'b1;
        cnt_wdata = dec_cnt;
        if (dec_cnt == '0) begin
          occ_we    = 1'b1;
          occ_waddr = tgt_q[AW-1:CB];
          occ_wdata = occ_rdata_q & ~(W'(1) << tgt_q[CB-1:0]);
        end
        dist_d      = dsum[nprs_pkg::DIST_W] ? nprs_pkg::DIST_MAX
                                             : dsum[nprs_pkg::DIST_W-1:0];
        head_d      = tgt_q;
        rpush       = 1'b1;
        rres.served = 1'b1;
        rres.pos    = tgt_x_pos(tgt_q);
        rres.total  = dist_d;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      head_q  <= '0;
      dir_q   <= 1'b1;
      dist_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      dir_q   <= dir_d;
      dist_q  <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    left_q  <= left_d;
    right_q <= right_d;
    tgt_q   <= tgt_d;
    addr_q  <= addr_d;
    hl_q    <= hl_d;
    hr_q    <= hr_d;
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (occ_re) begin
      occ_rdata_q <= occ_mem[occ_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
    end
  end

  // result queue, two beats deep
  assign empty             = (rcnt_q == 2'd0);
  assign rdo_rd            = pop && !empty;
  assign served_o          = res_q[rrd_q].served;
  assign served_position_o = res_q[rrd_q].pos;
  assign total_distance_o  = res_q[rrd_q].total;

  always_comb begin
    rcnt_d = rcnt_q;
    if (rpush && !rdo_rd) begin
      rcnt_d = rcnt_q + 2'd1;
    end else if (!rpush && rdo_rd) begin
      rcnt_d = rcnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= 2'd0;
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
    end else begin
      rcnt_q <= rcnt_d;
      if (rpush) begin
        rwr_q <= ~rwr_q;
      end
      if (rdo_rd) begin
        rrd_q <= ~rrd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpush) begin
      res_q[rwr_q] <= rres;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nearest_pending_request_server.sv @@
// nearest_pending_request_server: top level with the track length register
// an add reads then writes the count store; a serve waits while the result queue
// is full, then scans occupancy rows (W positions a row, 32 if POSITIONS >= 32;
// start row down to 0, head row up to the bound row), one row read a cycle,
// then decides and updates. After reset a clearing pass clears the occupancy rows;
// beats are queued meanwhile. head resets to 0, direction rightward, total to 0
`default_nettype none

module nearest_pending_request_server #(
  parameter int unsigned POSITIONS  = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [nprs_pkg::POS_W-1:0]  cfg_wdata_i,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        req_type_i,
  input  wire logic [nprs_pkg::POS_W-1:0]  position_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             served_o,
  output logic [nprs_pkg::POS_W-1:0]       served_position_o,
  output logic [nprs_pkg::DIST_W-1:0]      total_distance_o
);

  logic [nprs_pkg::POS_W-1:0] track_length_q;
  logic                       cmd_valid, cmd_pop;
  nprs_pkg::cmd_t             cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_length_q <= {nprs_pkg::POS_W{1'b1}};
    end else if (cfg_we_i) begin
      track_length_q <= cfg_wdata_i;
    end
  end

  nprs_front #(
    .POSITIONS(POSITIONS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .track_length_i (track_length_q),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  nprs_back #(
    .POSITIONS (POSITIONS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .track_length_i    (track_length_q),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .served_o          (served_o),
    .served_position_o (served_position_o),
    .total_distance_o  (total_distance_o)
  );

endmodule

`default_nettype wire
